// ===== hdl/bad_pkg.sv =====
package bad_pkg;

  // Bus function codes
  localparam logic [1:0] FUNC_READ     = 2'd0;
  localparam logic [1:0] FUNC_PEEK     = 2'd1;
  localparam logic [1:0] FUNC_WRITE    = 2'd2;
  localparam logic [1:0] FUNC_REGISTER = 2'd3;

  // Result target codes
  localparam logic [2:0] TGT_RAM      = 3'd0;
  localparam logic [2:0] TGT_ROM      = 3'd1;
  localparam logic [2:0] TGT_DEVICE   = 3'd2;
  localparam logic [2:0] TGT_UNMAPPED = 3'd3;
  localparam logic [2:0] TGT_REGISTER = 3'd4;

  localparam logic [31:0] ROM_BASE = 32'h0200_0000;

  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 16;
  localparam int LEN_W   = 8;
  localparam int KIND_W  = 8;
  localparam int SEL_W   = 8;
  localparam int TGT_W   = 3;
  localparam int FUNC_W  = 2;
  localparam int LIMIT_W = 17;

  localparam logic [LIMIT_W-1:0] RAM_LIMIT_RESET = 17'h1_0000;

  // Controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic decode;
    logic scan_step;
    logic finish;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/bad_in_if.sv =====
interface bad_in_if import bad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] bus_address;
  logic [DATA_W-1:0] write_data;
  logic [LEN_W-1:0]  dev_length;
  logic [KIND_W-1:0] dev_kind;

  modport source (
    output valid, func, bus_address, write_data, dev_length, dev_kind,
    input  ready
  );
  modport sink (
    input  valid, func, bus_address, write_data, dev_length, dev_kind,
    output ready
  );
endinterface

// ===== hdl/bad_out_if.sv =====
interface bad_out_if import bad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TGT_W-1:0]  target;
  logic [DATA_W-1:0] read_data;
  logic [SEL_W-1:0]  device_select;
  logic              device_peek;
  logic              accepted;

  modport source (
    output valid, target, read_data, device_select, device_peek, accepted,
    input  ready
  );
  modport sink (
    input  valid, target, read_data, device_select, device_peek, accepted,
    output ready
  );
endinterface

// ===== hdl/bad_ctrl.sv =====
module bad_ctrl import bad_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = status.need_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_accept_to_decode: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECODE)
    else $error("accepted beat did not start decode");

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free && state == S_FINISH)
    else $error("result loaded while output slot busy");

endmodule

// ===== hdl/bad_dp.sv =====
module bad_dp import bad_pkg::*; #(
  parameter int RAM_WORDS   = 65536,
  parameter int MAX_DEVICES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic [FUNC_W-1:0]  func,
  input  logic [ADDR_W-1:0]  bus_address,
  input  logic [DATA_W-1:0]  write_data,
  input  logic [LEN_W-1:0]   dev_length,
  input  logic [KIND_W-1:0]  dev_kind,
  input  cmd_t               cmd,
  output status_t            status,
  bad_out_if.source          out_ch
);

  localparam int RAM_AW  = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam int LIM_W   = ($clog2(RAM_WORDS + 1) > LIMIT_W) ? $clog2(RAM_WORDS + 1) : LIMIT_W;
  localparam int IDX_W   = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W   = $clog2(MAX_DEVICES + 1);
  localparam int POS_W   = $clog2(3 * MAX_DEVICES + 1);

  // Config
  logic [LIMIT_W-1:0] ram_limit;

  // Item registers
  logic [FUNC_W-1:0] func_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic [LEN_W-1:0]  len_q;
  logic [KIND_W-1:0] kind_q;

  // Window table
  logic [ADDR_W-1:0] win_base  [MAX_DEVICES];
  logic [LEN_W-1:0]  win_len   [MAX_DEVICES];
  logic [KIND_W-1:0] win_class [MAX_DEVICES];
  logic [CNT_W-1:0]  count;

  // RAM
  logic [DATA_W-1:0] ram [RAM_WORDS];
  logic [DATA_W-1:0] ram_q;
  logic [RAM_AW-1:0] clear_addr;

  // Decode results
  logic [MAX_DEVICES-1:0] hit_q;
  logic                   reg_ok_q;

  // ROM scan
  logic [CNT_W-1:0]  scan_idx;
  logic [POS_W-1:0]  rom_last;
  logic [DATA_W-1:0] rom_word;

  // Output register
  logic              out_valid;
  logic [TGT_W-1:0]  out_target;
  logic [DATA_W-1:0] out_data;
  logic [SEL_W-1:0]  out_sel;
  logic              out_peek;
  logic              out_acc;

  logic [LIM_W-1:0]       lim_ext;
  logic [LIM_W-1:0]       eff_lim;
  logic [ADDR_W-1:0]      eff_lim_a;
  logic                   is_reg;
  logic                   in_ram;
  logic [RAM_AW-1:0]      ram_idx;
  logic [ADDR_W-1:0]      rom_off;
  logic                   table_full;
  logic [MAX_DEVICES-1:0] hit;
  logic [IDX_W-1:0]       scan_i;
  logic [IDX_W-1:0]       wr_i;
  logic                   scan_above;
  logic [ADDR_W-1:0]      pos1;
  logic [ADDR_W-1:0]      pos2;
  logic [ADDR_W-1:0]      pos3;
  logic [MAX_DEVICES-1:0] sel_vec;
  logic [MAX_DEVICES+SEL_W-1:0] sel_pad;
  logic                   rom_hit;

  // Effective RAM limit, saturated to the RAM depth
  always_comb begin
    lim_ext   = LIM_W'(ram_limit);
    eff_lim   = (lim_ext < LIM_W'(RAM_WORDS)) ? lim_ext : LIM_W'(RAM_WORDS);
    eff_lim_a = ADDR_W'(eff_lim);
    is_reg    = (func_q == FUNC_REGISTER);
    in_ram    = (addr_q < eff_lim_a);
    ram_idx   = addr_q[RAM_AW-1:0];
    rom_off   = addr_q - ROM_BASE;
    table_full = (count == CNT_W'(MAX_DEVICES));
    scan_i    = scan_idx[IDX_W-1:0];
    wr_i      = count[IDX_W-1:0];
  end

  // Parallel window compare, one lane per table entry
  always_comb begin
    for (int i = 0; i < MAX_DEVICES; i++) begin
      hit[i] = (CNT_W'(i) < count) && (addr_q >= win_base[i]) &&
               ({1'b0, addr_q} < ({1'b0, win_base[i]} + (ADDR_W + 1)'(win_len[i])));
    end
  end

  // Scan positions of the current window within the descriptor ROM
  always_comb begin
    scan_above = (win_base[scan_i] >= eff_lim_a);
    pos1       = ADDR_W'(rom_last) + ADDR_W'(1);
    pos2       = ADDR_W'(rom_last) + ADDR_W'(2);
    pos3       = ADDR_W'(rom_last) + ADDR_W'(3);
  end

  always_comb begin
    status.clear_last = (clear_addr == RAM_AW'(RAM_WORDS - 1));
    status.need_scan  = !is_reg && !in_ram && (addr_q >= ROM_BASE);
    status.scan_done  = (scan_idx == count);
    status.out_free   = !out_valid || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_limit <= RAM_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      ram_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      addr_q <= bus_address;
      data_q <= write_data;
      len_q  <= dev_length;
      kind_q <= dev_kind;
    end
  end

  // RAM: clear sweep after reset, one access per item otherwise
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      ram[clear_addr] <= '0;
    end else if (cmd.decode && !is_reg && in_ram && func_q == FUNC_WRITE) begin
      ram[ram_idx] <= data_q;
    end
    if (cmd.decode) begin
      ram_q <= ram[ram_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + RAM_AW'(1);
    end
  end

  // Window table writes
  always_ff @(posedge clk) begin
    if (cmd.decode && is_reg && !table_full) begin
      win_base[wr_i]  <= addr_q;
      win_len[wr_i]   <= len_q;
      win_class[wr_i] <= kind_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.decode && is_reg && !table_full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      hit_q    <= hit;
      reg_ok_q <= is_reg && !table_full;
    end
  end

  // ROM scan: walk the table in order, counting windows at or above the RAM limit
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rom_last <= '0;
    end else if (cmd.decode) begin
      scan_idx <= '0;
      rom_last <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + CNT_W'(1);
      if (scan_above) rom_last <= rom_last + POS_W'(3);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      rom_word <= '0;
    end else if (cmd.scan_step && scan_above) begin
      if (rom_off == pos1) begin
        rom_word <= win_base[scan_i][15:0];
      end else if (rom_off == pos2) begin
        rom_word <= win_base[scan_i][31:16];
      end else if (rom_off == pos3) begin
        rom_word <= {win_class[scan_i], win_len[scan_i]};
      end
    end
  end

  // Result formation
  always_comb begin
    sel_vec = (func_q == FUNC_WRITE) ? hit_q : (hit_q & (~hit_q + MAX_DEVICES'(1)));
    sel_pad = {SEL_W'(0), sel_vec};
    rom_hit = (addr_q >= ROM_BASE) && (rom_off <= ADDR_W'(rom_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_target <= TGT_UNMAPPED;
      out_data   <= '0;
      out_sel    <= '0;
      out_peek   <= 1'b0;
      out_acc    <= 1'b0;
      if (is_reg) begin
        out_target <= TGT_REGISTER;
        out_acc    <= reg_ok_q;
      end else if (in_ram) begin
        out_target <= TGT_RAM;
        if (func_q != FUNC_WRITE) out_data <= ram_q;
      end else if (rom_hit) begin
        out_target <= TGT_ROM;
        if (func_q != FUNC_WRITE) begin
          out_data <= (rom_off == '0) ? DATA_W'(rom_last) : rom_word;
        end
      end else if (hit_q != '0) begin
        out_target <= TGT_DEVICE;
        out_sel    <= sel_pad[SEL_W-1:0];
        out_peek   <= (func_q == FUNC_PEEK);
      end
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.target        = out_target;
  assign out_ch.read_data     = out_data;
  assign out_ch.device_select = out_sel;
  assign out_ch.device_peek   = out_peek;
  assign out_ch.accepted      = out_acc;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DEVICES))
    else $error("window count past table size");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    cmd.decode && is_reg && table_full |=> count == $past(count) && !reg_ok_q)
    else $error("registration into full table");

  a_rom_bound: assert property (@(posedge clk) disable iff (rst)
    32'(rom_last) <= 32'(count) * 32'd3)
    else $error("descriptor length exceeds three words per window");

endmodule

// ===== hdl/bus_address_decoder.sv =====
// Bus address decoder: takes one bus beat at a time (read, peek, write, or
// register a device window) and returns one result beat per input beat, in
// order. After reset the block first zeroes the word RAM, one word per cycle,
// so in_ch.ready stays low until the sweep ends; ram_limit may be written at
// any time outside a pending access. A beat then passes the accept, decode and
// result steps on its way to the result register; an access at or above the
// descriptor ROM base 0x2000000 that misses RAM walks the window table one
// entry per cycle to locate its descriptor. A new beat is accepted while the
// previous result still waits in the output register; a full output register
// stalls only the result step.
// Reads and peeks pick the lowest-numbered matching window, writes signal
// every match; only the first eight windows appear in device_select.
module bus_address_decoder import bad_pkg::*; #(
  parameter int RAM_WORDS   = 65536,
  parameter int MAX_DEVICES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  bad_in_if.sink             in_ch,
  bad_out_if.source          out_ch
);

  cmd_t    cmd;     // sequencer commands
  status_t status;  // datapath flags back to the sequencer
  logic    in_ready;

  bad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Beat is taken only when the sequencer sits idle
  assign in_ch.ready = in_ready;

  bad_dp #(
    .RAM_WORDS   (RAM_WORDS),
    .MAX_DEVICES (MAX_DEVICES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .func        (in_ch.func),
    .bus_address (in_ch.bus_address),
    .write_data  (in_ch.write_data),
    .dev_length  (in_ch.dev_length),
    .dev_kind    (in_ch.dev_kind),
    .cmd         (cmd),
    .status      (status),
    .out_ch      (out_ch)
  );

endmodule

// ===== bench/tb_bus_address_decoder.sv =====
`timescale 1ns / 100ps

module tb_bus_address_decoder;
  import bad_pkg::*;

  // Receiver holdoff length; long enough for the pipeline and the output
  // register to fill so the block has to drop in_ch.ready.
  localparam int HOLD_CYCLES = 300;
  localparam logic [16:0] RAM_SPAN = 17'h1_0000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic [LEN_W-1:0]  len;
    logic [KIND_W-1:0] kind;
  } bus_access_t;

  typedef struct packed {
    logic [TGT_W-1:0]  target;
    logic [DATA_W-1:0] rdata;
    logic [SEL_W-1:0]  sel;
    logic              peek;
    logic              acc;
  } decode_result_t;

  logic clk;
  logic rst;
  logic               cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;

  bad_in_if  in_ch ();
  bad_out_if out_ch ();

  bus_address_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------
  // Shadow state of the decoder: word RAM, window table, ram_limit.
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0]  ram_shadow [0:65535];
  logic [ADDR_W-1:0]  win_base   [0:7];
  logic [LEN_W-1:0]   win_len    [0:7];
  logic [KIND_W-1:0]  win_class  [0:7];
  int                 win_count;
  logic [LIMIT_W-1:0] ram_limit_q;

  decode_result_t expected_results [$];
  int             errors = 0;

  // Traffic shaping, owned by the test sequence
  int send_idle_pct = 28;
  int recv_idle_pct = 67;
  int hold_req = 0;

  // ram_limit saturates at the physical RAM size
  function automatic logic [16:0] eff_limit();
    return (ram_limit_q > RAM_SPAN) ? RAM_SPAN : ram_limit_q;
  endfunction

  // Predicts one result beat and applies the side effects of the access.
  function automatic decode_result_t decode_access(bus_access_t a);
    decode_result_t r;
    logic [16:0]       lim;
    int                n;
    int                seen;
    logic [ADDR_W-1:0] k;
    logic [ADDR_W-1:0] j;
    logic [ADDR_W-1:0] part;
    logic [32:0]       top;
    logic              done;
    r = '0;
    r.target = TGT_UNMAPPED;
    lim = eff_limit();
    if (a.func == FUNC_REGISTER) begin
      r.target = TGT_REGISTER;
      if (win_count < 8) begin
        win_base[win_count]  = a.addr;
        win_len[win_count]   = a.len;
        win_class[win_count] = a.kind;
        win_count++;
        r.acc = 1'b1;
      end
    end else if (a.addr < lim) begin
      r.target = TGT_RAM;
      if (a.func == FUNC_WRITE) ram_shadow[a.addr[15:0]] = a.wdata;
      else r.rdata = ram_shadow[a.addr[15:0]];
    end else begin
      // descriptor ROM lists only the windows at or above the RAM limit
      n = 0;
      for (int i = 0; i < win_count; i++)
        if (win_base[i] >= lim) n++;
      if (a.addr >= ROM_BASE && (a.addr - ROM_BASE) <= 3 * n) begin
        r.target = TGT_ROM;
        k = a.addr - ROM_BASE;
        if (a.func != FUNC_WRITE) begin
          if (k == 0) begin
            r.rdata = DATA_W'(3 * n);
          end else begin
            j = (k - 1) / 3;
            part = (k - 1) % 3;
            seen = 0;
            for (int i = 0; i < win_count; i++) begin
              if (win_base[i] >= lim) begin
                if (seen == j) begin
                  if (part == 0) r.rdata = win_base[i][15:0];
                  else if (part == 1) r.rdata = win_base[i][31:16];
                  else r.rdata = {win_class[i], win_len[i]};
                end
                seen++;
              end
            end
          end
        end
      end else begin
        // reads and peeks stop at the lowest hit, writes collect all hits
        done = 1'b0;
        for (int i = 0; i < win_count; i++) begin
          top = {1'b0, win_base[i]} + 33'(win_len[i]);
          if (!done && {1'b0, a.addr} >= {1'b0, win_base[i]} && {1'b0, a.addr} < top) begin
            r.sel[i] = 1'b1;
            r.target = TGT_DEVICE;
            if (a.func != FUNC_WRITE) done = 1'b1;
          end
        end
        if (r.target == TGT_DEVICE && a.func == FUNC_PEEK) r.peek = 1'b1;
      end
    end
    return r;
  endfunction

  // Random access biased toward RAM, the ROM, and the edges of the windows;
  // the rest is full-range noise and an occasional registration.
  function automatic bus_access_t random_access();
    bus_access_t a;
    logic [16:0] lim;
    int          pick;
    int          w;
    lim = eff_limit();
    a.func  = FUNC_W'($urandom_range(2));
    a.addr  = $urandom;
    a.wdata = DATA_W'($urandom);
    a.len   = LEN_W'($urandom);
    a.kind  = KIND_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 6) begin
      a.func = FUNC_REGISTER;
    end else if (pick < 35) begin
      if (lim != 0) begin
        if ($urandom_range(3) == 0) a.addr = 32'(lim) - 1 + $urandom_range(1);
        else a.addr = $urandom_range(32'(lim) - 1);
      end
    end else if (pick < 50) begin
      a.addr = ROM_BASE + $urandom_range(26);
    end else if (pick < 85 && win_count > 0) begin
      w = $urandom_range(win_count - 1);
      a.addr = win_base[w] + $urandom_range(32'(win_len[w]) + 3) - 2;
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  task automatic send_beat(input bus_access_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= a.func;
    in_ch.bus_address <= a.addr;
    in_ch.write_data  <= a.wdata;
    in_ch.dev_length  <= a.len;
    in_ch.dev_kind    <= a.kind;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(decode_access(a));
  endtask

  task automatic send_access(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    bus_access_t a;
    a = '{func: f, addr: addr, wdata: data, len: LEN_W'($urandom), kind: KIND_W'($urandom)};
    send_beat(a);
  endtask

  task automatic send_register(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
                               input logic [KIND_W-1:0] cls);
    bus_access_t a;
    a = '{func: FUNC_REGISTER, addr: base, wdata: DATA_W'($urandom), len: len, kind: cls};
    send_beat(a);
  endtask

  // Sender stays quiet until every outstanding result beat has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [LIMIT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ram_limit_q = v;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random ready, plus a long holdoff when the sequence asks
  // ---------------------------------------------------------------------
  initial begin
    int hold_ack;
    int hold_left;
    hold_ack = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted result beat against the oldest prediction
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    decode_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no access outstanding");
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("target", want.target, out_ch.target);
        check_field("read_data", want.rdata, out_ch.read_data);
        check_field("device_select", want.sel, out_ch.device_select);
        check_field("device_peek", want.peek, out_ch.device_peek);
        check_field("accepted", want.acc, out_ch.accepted);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // RAM round trips at both ends of the RAM, empty descriptor ROM.
  // ram_limit is written above the RAM size so the saturation is exercised.
  task automatic test_basic_access();
    cfg_write(17'h1_FFFF);
    send_access(FUNC_READ,  32'h0000_0000, 16'h0000);   // cleared after reset
    send_access(FUNC_WRITE, 32'h0000_0000, 16'hFFFF);
    send_access(FUNC_WRITE, 32'h0000_FFFF, 16'hA5A5);
    send_access(FUNC_READ,  32'h0000_0000, 16'h0000);
    send_access(FUNC_PEEK,  32'h0000_FFFF, 16'h0000);
    send_access(FUNC_READ,  ROM_BASE,      16'h0000);   // count word only
    send_access(FUNC_WRITE, ROM_BASE + 1,  16'h1234);   // past ROM, no windows
  endtask

  // Fills the window table, overflows it, then walks the descriptor ROM and
  // the window compare: overlap, no-wrap top window, zero length window.
  task automatic test_window_table();
    send_register(32'h0000_F000, 8'h20, 8'h01);   // inside RAM until limit drops
    send_register(32'h0001_0000, 8'hFF, 8'h02);   // between RAM and ROM
    send_register(32'h0001_0080, 8'h40, 8'h03);   // overlaps window 1
    send_register(ROM_BASE,      8'h30, 8'h04);   // shadowed by the ROM head
    send_register(32'hFFFF_FF80, 8'hFF, 8'h05);   // end passes 2^32, no wrap
    send_register(32'h00AB_CDEF, 8'h00, 8'h06);   // zero length, never hits
    send_register(32'h0001_0000, 8'h10, 8'h07);   // same base as window 1
    send_register(32'h8000_1234, 8'h80, 8'hFF);
    send_register(32'h0000_0100, 8'h10, 8'h00);   // table full, refused
    send_access(FUNC_READ,  ROM_BASE,      16'h0000);
    send_access(FUNC_PEEK,  ROM_BASE + 1,  16'h0000);
    send_access(FUNC_READ,  ROM_BASE + 21, 16'h0000);
    send_access(FUNC_WRITE, ROM_BASE + 2,  16'hBEEF); // ROM write is dropped
    send_access(FUNC_READ,  32'h0001_0000, 16'h0000);
    send_access(FUNC_WRITE, 32'h0001_0000, 16'h5A5A); // windows 1 and 6
    send_access(FUNC_PEEK,  32'h0001_00A0, 16'h0000);
    send_access(FUNC_READ,  ROM_BASE + 22, 16'h0000); // window 3 past the ROM
    send_access(FUNC_READ,  32'hFFFF_FFFF, 16'h0000);
    send_access(FUNC_WRITE, 32'h00AB_CDEF, 16'h0F0F); // unmapped write
  endtask

  task automatic test_random_traffic(input logic [LIMIT_W-1:0] limit, input int count);
    drain_results();
    cfg_write(limit);
    repeat (count) send_beat(random_access());
  endtask

  // Receiver holds off while the sender keeps pushing, so the block backs up
  // into its input; then the sender waits out every result.
  task automatic test_backpressure();
    drain_results();
    hold_req++;
    repeat (40) send_beat(random_access());
    drain_results();
  endtask

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_READ;
    in_ch.bus_address = '0;
    in_ch.write_data  = '0;
    in_ch.dev_length  = '0;
    in_ch.dev_kind    = '0;
    foreach (ram_shadow[i]) ram_shadow[i] = '0;
    win_count   = 0;
    ram_limit_q = RAM_LIMIT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily (block is still clearing RAM)
    send_idle_pct = 28;
    recv_idle_pct = 67;
    test_basic_access();
    test_window_table();
    test_random_traffic(17'h1_0000, 100);
    test_random_traffic(17'h0_0000, 100);   // everything misses RAM

    // roles swapped
    send_idle_pct = 67;
    recv_idle_pct = 28;
    test_random_traffic(17'h0_F010, 100);   // window 0 half in RAM
    test_random_traffic(17'h0_0001, 100);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(LIMIT_W'($urandom_range(17'h1_FFFF)), 100);
    test_random_traffic(17'h1_FFFF, 100);

    drain_results();
    repeat (20) @(posedge clk);   // catch stray beats after the last result
    if (errors == 0) begin
      $display("bus_address_decoder regression: pass");
    end else begin
      $display("bus_address_decoder regression: fail");
    end
    $finish;
  end

  // Watchdog: a timeout well above the slowest legal run, including
  // the RAM clear after reset.
  initial begin
    #12_000_000;
    $display("bus_address_decoder regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bad_pkg.sv
hdl/bad_in_if.sv
hdl/bad_out_if.sv
hdl/bad_ctrl.sv
hdl/bad_dp.sv
hdl/bus_address_decoder.sv
bench/tb_bus_address_decoder.sv
